// ===== rtl/cmsu_pkg.sv =====
// ----------------------------------------------------------------------------
// cmsu_pkg: shared types and constants for the count-max sketch update
// Holds the flow key layout, the bucket entry layout, the hash multiplier
// and the defaults for the block's parameters and configuration register.
// ----------------------------------------------------------------------------
package cmsu_pkg;

	// Hash multiplier applied before each key field is folded in
	localparam logic [31:0] HASH_MUL = 32'd397;

	// Default sizes
	localparam int BUCKETS_DEF = 8192;
	localparam int ROWS_DEF    = 2;

	// Bucket count register
	localparam int              CFG_W     = 14;
	localparam logic [CFG_W-1:0] CFG_RESET = 14'd8192;

	// Five-tuple flow key, 112 bits
	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] proto;
	} key_t;

	// One bucket: stored key and its counter
	typedef struct packed {
		key_t        key;
		logic [31:0] count;
	} entry_t;

endpackage

// ===== rtl/cmsu_index_unit.sv =====
// ----------------------------------------------------------------------------
// cmsu_index_unit: flow hash and iterative bucket index
// Folds the key into a 32-bit hash over four multiply-and-XOR steps, then
// reduces it modulo the bucket count with a restoring remainder unit that
// retires one dividend bit per cycle. Pulses done with the index.
// ----------------------------------------------------------------------------
module cmsu_index_unit #(
	parameter int IDX_W = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  cmsu_pkg::key_t             key,
	input  logic [cmsu_pkg::CFG_W-1:0] divisor,
	output logic                       done,
	output logic [IDX_W-1:0]           idx
);
	import cmsu_pkg::*;

	typedef enum logic [2:0] {
		IU_IDLE = 3'b001,
		IU_HASH = 3'b010,
		IU_DIV  = 3'b100
	} iu_state_t;

	localparam logic [4:0] HASH_LAST = 5'd3;
	localparam logic [4:0] DIV_LAST  = 5'd31;

	iu_state_t        state_q;
	logic [4:0]       step_q;
	logic             done_q;
	logic [31:0]      hash_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] div_q;

	logic [31:0]      hash_mul;
	logic [31:0]      fold_field;
	logic [31:0]      hash_next;
	logic [CFG_W:0]   trial;
	logic [CFG_W:0]   trial_sub;
	logic             trial_ge;
	logic [CFG_W-1:0] rem_next;

	// One hash step: multiply, then fold in the next key field
	assign hash_mul = hash_q * HASH_MUL;

	always_comb begin
		case (step_q[1:0])
			2'd0:    fold_field = key.dst_ip;
			2'd1:    fold_field = {16'd0, key.src_port};
			2'd2:    fold_field = {16'd0, key.dst_port};
			2'd3:    fold_field = {16'd0, key.proto};
			default: fold_field = '0;
		endcase
	end

	assign hash_next = hash_mul ^ fold_field;

	// One remainder step: shift in the next dividend bit, subtract if it fits
	assign trial     = {rem_q, hash_q[31]};
	assign trial_sub = trial - {1'b0, div_q};
	assign trial_ge  = trial >= {1'b0, div_q};
	assign rem_next  = trial_ge ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IU_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				IU_IDLE: begin
					if (start) begin
						state_q <= IU_HASH;
						step_q  <= '0;
					end
				end
				IU_HASH: begin
					if (step_q == HASH_LAST) begin
						state_q <= IU_DIV;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				IU_DIV: begin
					if (step_q == DIV_LAST) begin
						state_q <= IU_IDLE;
						done_q  <= 1'b1;
					end
					step_q <= step_q + 5'd1;
				end
				default: begin
					state_q <= IU_IDLE;
				end
			endcase
		end
	end

	// Datapath: hash register doubles as the dividend shift register
	always_ff @(posedge clk) begin
		case (state_q)
			IU_IDLE: begin
				if (start) begin
					hash_q <= key.src_ip;
					div_q  <= divisor;
				end
			end
			IU_HASH: begin
				hash_q <= hash_next;
				if (step_q == HASH_LAST) begin
					rem_q <= '0;
				end
			end
			IU_DIV: begin
				rem_q  <= rem_next;
				hash_q <= {hash_q[30:0], 1'b0};
			end
			default: begin
				hash_q <= hash_q;
			end
		endcase
	end

	assign done = done_q;
	assign idx  = IDX_W'(rem_q);

`ifndef ASSERT_OFF
	// Partial remainder stays below the divisor throughout the division
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == IU_DIV) |-> (rem_q < div_q))
		else $error("remainder not below divisor");

	// Done is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held for more than one cycle");
`endif

endmodule

// ===== rtl/cmsu_bucket_ram.sv =====
// ----------------------------------------------------------------------------
// cmsu_bucket_ram: bucket store with clearing pass
// Single-port memory of key and counter entries, one row after another.
// After reset a sweep writes zero to every entry, one per cycle, and busy
// stays high until it finishes. Read data is registered.
// ----------------------------------------------------------------------------
module cmsu_bucket_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  logic                    wr_en,
	input  logic [AW-1:0]           addr,
	input  cmsu_pkg::entry_t        wdata,
	output cmsu_pkg::entry_t        rdata,
	output logic                    busy
);
	import cmsu_pkg::*;

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	entry_t        mem [DEPTH];
	entry_t        rdata_q;
	logic [AW-1:0] clr_q;
	logic          busy_q;

	// Advance the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (clr_q == LAST_ADDR) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Memory port: sweep writes take priority, reads are registered
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

`ifndef ASSERT_OFF
	// No access is requested while the sweep owns the port
	a_no_access_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !(rd_en || wr_en))
		else $error("memory access during clearing pass");
`endif

endmodule

// ===== rtl/count_max_sketch_update.sv =====
// ----------------------------------------------------------------------------
// count_max_sketch_update: count-max sketch update for flow records
// Input channel (in_valid / in_stall) takes one flow record: five-tuple key
// and update_amount. Output channel (out_valid / out_stall) returns one
// item per record: the bucket index, whether row zero's key was replaced,
// and row zero's counter after the update. Configuration channel
// (cfg_valid / cfg_ready) writes the bucket count; write only while idle.
// A record passes through four hash steps, the bit-serial remainder unit,
// and a read then a write on the single memory port for each row. A new
// record can be taken in the cycle after the result is loaded, and not
// before the last one is finished. After reset the store is swept to zero
// with in_stall high; configuration writes are taken meanwhile. A stalled
// result holds in the output register; the block finishes the next record
// and waits in its last state until the register is free.
// ----------------------------------------------------------------------------
module count_max_sketch_update #(
	parameter int  BUCKETS = cmsu_pkg::BUCKETS_DEF,
	parameter int  ROWS    = cmsu_pkg::ROWS_DEF,
	localparam int IDX_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cmsu_pkg::CFG_W-1:0] cfg_data,
	// input items
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [31:0]                src_ip,
	input  logic [31:0]                dst_ip,
	input  logic [15:0]                src_port,
	input  logic [15:0]                dst_port,
	input  logic [15:0]                proto,
	input  logic [31:0]                update_amount,
	// result items
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [IDX_W-1:0]           bucket_index,
	output logic                       key_replaced,
	output logic [31:0]                count_after
);
	import cmsu_pkg::*;

	localparam int DEPTH = ROWS * BUCKETS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [CFG_W-1:0] CFG_MAX       = {CFG_W{1'b1}};
	localparam logic [CFG_W-1:0] BUCKETS_CLAMP =
		(BUCKETS > (2 ** CFG_W - 1)) ? CFG_MAX : CFG_W'(BUCKETS);
	localparam logic [CFG_W-1:0] ONE_BUCKET = CFG_W'(1);
	localparam logic [RW-1:0]    LAST_ROW   = RW'(ROWS - 1);
	localparam logic [AW-1:0]    ROW_STRIDE = AW'(BUCKETS);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_INDEX  = 5'b00010,
		ST_READ   = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_FINISH = 5'b10000
	} st_t;

	st_t              state_q;
	logic [CFG_W-1:0] cfg_q;
	logic [CFG_W-1:0] eff_count;
	key_t             key_q;
	logic [31:0]      amount_q;
	logic [IDX_W-1:0] idx_q;
	logic [AW-1:0]    addr_q;
	logic [RW-1:0]    row_q;
	logic             rep0_q;
	logic [31:0]      cnt0_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_rep_q;
	logic [31:0]      out_cnt_q;

	logic             accept;
	logic             iu_start;
	key_t             iu_key;
	logic             iu_done;
	logic [IDX_W-1:0] iu_idx;
	logic             ram_busy;
	logic             ram_rd;
	logic             ram_wr;
	entry_t           ram_rdata;
	entry_t           ram_wdata;
	logic             load_out;

	logic             key_match;
	logic [32:0]      sum;
	logic             amount_gt;
	logic [31:0]      new_count;
	logic             row_rep;

	// Configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// Clamp the bucket count into one to BUCKETS
	always_comb begin
		if (cfg_q == '0) begin
			eff_count = ONE_BUCKET;
		end else if (cfg_q > BUCKETS_CLAMP) begin
			eff_count = BUCKETS_CLAMP;
		end else begin
			eff_count = cfg_q;
		end
	end

	// Input handshake
	assign in_stall = (state_q != ST_IDLE) || ram_busy;
	assign accept   = in_valid && !in_stall;
	assign iu_start = accept;

	// The index unit latches src_ip at start, before key_q is loaded, so
	// hand it the port-level key on that cycle and key_q afterwards
	assign iu_key = accept ? key_t'({src_ip, dst_ip, src_port, dst_port, proto}) : key_q;

	cmsu_index_unit #(
		.IDX_W (IDX_W)
	) u_index (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (iu_start),
		.key     (iu_key),
		.divisor (eff_count),
		.done    (iu_done),
		.idx     (iu_idx)
	);

	assign ram_rd    = (state_q == ST_READ);
	assign ram_wr    = (state_q == ST_UPDATE);

	cmsu_bucket_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (ram_rd),
		.wr_en  (ram_wr),
		.addr   (addr_q),
		.wdata  (ram_wdata),
		.rdata  (ram_rdata),
		.busy   (ram_busy)
	);

	// Row update: add on a key match, otherwise decrement or take over
	assign key_match = (ram_rdata.key == key_q);
	assign sum       = {1'b0, ram_rdata.count} + {1'b0, amount_q};
	assign amount_gt = amount_q > ram_rdata.count;

	always_comb begin
		row_rep = 1'b0;
		if (key_match) begin
			new_count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end else if (amount_gt) begin
			new_count = amount_q - ram_rdata.count;
			row_rep   = 1'b1;
		end else begin
			new_count = ram_rdata.count - amount_q;
		end
		ram_wdata.count = new_count;
		ram_wdata.key   = row_rep ? key_q : ram_rdata.key;
	end

	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_INDEX;
					end
				end
				ST_INDEX: begin
					if (iu_done) begin
						state_q <= ST_READ;
						row_q   <= '0;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (row_q == LAST_ROW) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_READ;
						row_q   <= row_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item and per-row payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q.src_ip   <= src_ip;
			key_q.dst_ip   <= dst_ip;
			key_q.src_port <= src_port;
			key_q.dst_port <= dst_port;
			key_q.proto    <= proto;
			amount_q       <= update_amount;
		end
		if ((state_q == ST_INDEX) && iu_done) begin
			idx_q  <= iu_idx;
			addr_q <= AW'(iu_idx);
		end
		if (state_q == ST_UPDATE) begin
			addr_q <= addr_q + ROW_STRIDE;
			if (row_q == '0) begin
				rep0_q <= row_rep;
				cnt0_q <= new_count;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_idx_q <= idx_q;
			out_rep_q <= rep0_q;
			out_cnt_q <= cnt0_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign bucket_index = out_idx_q;
	assign key_replaced = out_rep_q;
	assign count_after  = out_cnt_q;

`ifndef ASSERT_OFF
	// An accepted item keeps the input stalled on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled after accepting an item");

	// A new result only comes from the finishing state
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result loaded outside finishing state");

	// A reported index is below the bucket count in use
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (32'(out_idx_q) < 32'(eff_count)))
		else $error("bucket index out of range");
`endif

endmodule

// ===== sim/count_max_sketch_update_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// count_max_sketch_update_test: self-checking bench for the sketch update
// Drives flow records through the stall handshake, predicts each bucket
// update against a private copy of both sketch rows, and compares every
// result item in order. Bucket count settings sweep from zero to past the top.
// ----------------------------------------------------------------------------

localparam int SKETCH_BUCKETS = cmsu_pkg::BUCKETS_DEF;
localparam int SKETCH_ROWS    = cmsu_pkg::ROWS_DEF;
localparam int SKETCH_IDX_W   = $clog2(SKETCH_BUCKETS);

// Shadow sketch: predicts every update and checks result items in order
class sketch_scoreboard;
	typedef struct {
		logic [SKETCH_IDX_W-1:0] index;
		logic                    replaced;
		logic [31:0]             count;
	} update_t;

	cmsu_pkg::key_t             row_keys[SKETCH_ROWS][SKETCH_BUCKETS];
	logic [31:0]                row_counts[SKETCH_ROWS][SKETCH_BUCKETS];
	logic [cmsu_pkg::CFG_W-1:0] bucket_count;
	update_t                    expected_updates[$];
	int                         mismatches;

	function new();
		foreach (row_keys[r, b]) begin
			row_keys[r][b]   = '0;
			row_counts[r][b] = '0;
		end
		bucket_count = cmsu_pkg::CFG_RESET;
		mismatches   = 0;
	endfunction

	function void set_bucket_count(logic [cmsu_pkg::CFG_W-1:0] value);
		bucket_count = value;
	endfunction

	function int pending();
		return expected_updates.size();
	endfunction

	// Multiply-and-fold over the five key fields, wrapping at 32 bits
	function logic [31:0] flow_hash(cmsu_pkg::key_t k);
		logic [31:0] h;
		h = k.src_ip;
		h = (h * cmsu_pkg::HASH_MUL) ^ k.dst_ip;
		h = (h * cmsu_pkg::HASH_MUL) ^ {16'd0, k.src_port};
		h = (h * cmsu_pkg::HASH_MUL) ^ {16'd0, k.dst_port};
		h = (h * cmsu_pkg::HASH_MUL) ^ {16'd0, k.proto};
		return h;
	endfunction

	// Apply one accepted flow record to every row and queue row zero's outcome
	function void note_flow(cmsu_pkg::key_t k, logic [31:0] amount);
		logic [31:0] span;
		logic [31:0] idx;
		logic [31:0] now;
		logic [32:0] sum;
		logic        rep;
		update_t     upd;
		span = 32'(bucket_count);
		if (span == 0)
			span = 1;
		if (span > SKETCH_BUCKETS)
			span = SKETCH_BUCKETS;
		idx = flow_hash(k) % span;
		upd.index    = idx[SKETCH_IDX_W-1:0];
		upd.replaced = 1'b0;
		upd.count    = '0;
		for (int r = 0; r < SKETCH_ROWS; r++) begin
			now = row_counts[r][idx];
			rep = 1'b0;
			if (row_keys[r][idx] == k) begin
				// matching key: add, pinned at the counter's top
				sum = {1'b0, now} + {1'b0, amount};
				row_counts[r][idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			end else if (amount > now) begin
				// amount outweighs the holder: take the bucket over
				row_counts[r][idx] = amount - now;
				row_keys[r][idx]   = k;
				rep = 1'b1;
			end else begin
				row_counts[r][idx] = now - amount;
			end
			if (r == 0) begin
				upd.replaced = rep;
				upd.count    = row_counts[0][idx];
			end
		end
		expected_updates.push_back(upd);
	endfunction

	function void check_result(logic [SKETCH_IDX_W-1:0] index, logic replaced,
			logic [31:0] count);
		update_t want;
		if (expected_updates.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: index %0d replaced %0b count %0h",
					index, replaced, count);
			return;
		end
		want = expected_updates.pop_front();
		if (index !== want.index || replaced !== want.replaced || count !== want.count) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected index %0d replaced %0b count %0h, got %0d %0b %0h",
					want.index, want.replaced, want.count, index, replaced, count);
		end
	endfunction
endclass

module count_max_sketch_update_test;

	localparam int WATCHDOG_LIMIT = 100000;
	localparam int LONG_HOLD      = 300;
	localparam int POOL_SIZE      = 24;
	localparam int PHASE_ITEMS    = 150;
	localparam int PHASES         = 10;

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic                         cfg_valid     = 1'b0;
	logic                         cfg_ready;
	logic [cmsu_pkg::CFG_W-1:0]   cfg_data      = '0;
	logic                         in_valid      = 1'b0;
	logic                         in_stall;
	logic [31:0]                  src_ip        = '0;
	logic [31:0]                  dst_ip        = '0;
	logic [15:0]                  src_port      = '0;
	logic [15:0]                  dst_port      = '0;
	logic [15:0]                  proto         = '0;
	logic [31:0]                  update_amount = '0;
	logic                         out_valid;
	logic                         out_stall     = 1'b0;
	logic [SKETCH_IDX_W-1:0]      bucket_index;
	logic                         key_replaced;
	logic [31:0]                  count_after;

	sketch_scoreboard sb;
	cmsu_pkg::key_t   flow_pool[POOL_SIZE];
	int               gap_pct       = 0;
	int               stall_pct     = 0;
	bit               hold_off_req  = 1'b0;
	int               idle_cycles   = 0;
	logic [cmsu_pkg::CFG_W-1:0] phase_setting[PHASES] =
		'{14'd16383, 14'd1, 14'd8191, 14'd7, 14'd0, 14'd100, 14'd8192, 14'd3, 14'd0, 14'd5000};

	count_max_sketch_update #(
		.BUCKETS(SKETCH_BUCKETS),
		.ROWS   (SKETCH_ROWS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.src_ip       (src_ip),
		.dst_ip       (dst_ip),
		.src_port     (src_port),
		.dst_port     (dst_port),
		.proto        (proto),
		.update_amount(update_amount),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bucket_index (bucket_index),
		.key_replaced (key_replaced),
		.count_after  (count_after)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Observe all three channels at the edge; stop if nothing moves for too long
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall == 1'b0)
			sb.check_result(bucket_index, key_replaced, count_after);
		if (in_valid == 1'b1 && in_stall === 1'b0)
			sb.note_flow(cmsu_pkg::key_t'{src_ip, dst_ip, src_port, dst_port, proto},
				update_amount);
		if (cfg_valid == 1'b1 && cfg_ready === 1'b1)
			sb.set_bucket_count(cfg_data);
		if ((out_valid === 1'b1 && !out_stall) || (in_valid && in_stall === 1'b0) ||
				(cfg_valid && cfg_ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("count_max_sketch_update_test: errors");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one flow record and hold it until taken
	task automatic send_flow(cmsu_pkg::key_t k, logic [31:0] amount);
		in_valid      <= 1'b1;
		src_ip        <= k.src_ip;
		dst_ip        <= k.dst_ip;
		src_port      <= k.src_port;
		dst_port      <= k.dst_port;
		proto         <= k.proto;
		update_amount <= amount;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
	endtask

	// Optional idle burst after an item
	task automatic sender_gap();
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every outstanding result; the first edge
	// lets the monitor note an item taken on the edge just passed
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_bucket_count(logic [cmsu_pkg::CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	function automatic cmsu_pkg::key_t random_flow();
		cmsu_pkg::key_t k;
		k.src_ip   = $urandom();
		k.dst_ip   = $urandom();
		k.src_port = 16'($urandom_range(0, 65535));
		k.dst_port = 16'($urandom_range(0, 65535));
		k.proto    = 16'($urandom_range(0, 65535));
		return k;
	endfunction

	// Mostly repeat flows from the pool so buckets see matches and contests
	function automatic cmsu_pkg::key_t pick_flow();
		cmsu_pkg::key_t k;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			k = flow_pool[$urandom_range(0, POOL_SIZE - 1)];
		end else if (sel < 85) begin
			k = flow_pool[$urandom_range(0, POOL_SIZE - 1)];
			k.dst_port = 16'($urandom_range(0, 65535));
		end else begin
			k = random_flow();
		end
		return k;
	endfunction

	function automatic logic [31:0] pick_amount();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return 32'd0;
		else if (sel < 40)
			return $urandom_range(1, 16);
		else if (sel < 70)
			return $urandom_range(0, 4096);
		else if (sel < 85)
			return $urandom();
		else if (sel < 92)
			return 32'hFFFF_FFFF;
		else
			return 32'hFFFF_FFFF - $urandom_range(0, 16);
	endfunction

	// Stimulus
	initial begin
		cmsu_pkg::key_t flow_a;
		cmsu_pkg::key_t flow_b;
		cmsu_pkg::key_t flow_zero;
		flow_a    = cmsu_pkg::key_t'{32'h0A00_0001, 32'hC0A8_0101, 16'd1234, 16'd80, 16'd6};
		flow_b    = '1;
		flow_zero = '0;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single bucket (zero written, read as one): every flow lands together
		write_bucket_count(14'd0);
		send_flow(flow_zero, 32'd5);           // cleared bucket matches the zero flow
		send_flow(flow_a, 32'd5);              // amount equals count: key kept
		send_flow(flow_a, 32'd0);              // zero amount on a mismatch
		send_flow(flow_a, 32'd7);              // take-over
		send_flow(flow_a, 32'hFFFF_FFFF);      // saturate
		send_flow(flow_a, 32'd1);              // stays saturated
		send_flow(flow_b, 32'd0);
		send_flow(flow_b, 32'hFFFF_FFFF);      // drains to zero, key kept
		send_flow(flow_b, 32'd3);
		send_flow(flow_a, 32'd1);

		// Above the top: clamps to the full row; field extremes
		drain();
		write_bucket_count(14'd16383);
		send_flow(flow_b, 32'hFFFF_FFFF);
		send_flow(flow_b, 32'hFFFF_FFFF);
		send_flow(flow_zero, 32'd0);
		send_flow(cmsu_pkg::key_t'{32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555,
			16'hAAAA}, 32'h5555_5555);
		send_flow(cmsu_pkg::key_t'{32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA,
			16'h5555}, 32'hAAAA_AAAA);
		send_flow(flow_zero, 32'hFFFF_FFFF);

		// Random phases, one bucket count each; every third phase and the last run without idling
		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p == 8)
				write_bucket_count(14'($urandom_range(1, 16383)));
			else
				write_bucket_count(phase_setting[p]);
			foreach (flow_pool[i])
				flow_pool[i] = random_flow();
			if (p == PHASES - 1 || p % 3 == 2) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = $urandom_range(5, 40);
				stall_pct = $urandom_range(5, 40);
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == 40)
					hold_off_req = 1'b1;
				if (p == 5 && i == 75)
					drain();
				send_flow(pick_flow(), pick_amount());
				sender_gap();
			end
		end

		drain();
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("count_max_sketch_update_test: clean");
		else
			$display("count_max_sketch_update_test: errors");
		$finish;
	end

endmodule
